[rtl/pcb_pkg.sv]
// ============================================================================
// pcb_pkg: shared constants and types for the piecewise cubic Bezier evaluator
// Widths, fixed-point constants, item codes and the lane control group.
// ============================================================================
`default_nettype none

package pcb_pkg;

    // Curve store and fixed-point format
    localparam int MAX_KNOTS     = 64;
    localparam int FRACTION_BITS = 16;

    localparam int COORD_W  = 32;                          // Q16.16 coordinate
    localparam int NUM_AXES = 3;
    localparam int ADDR_W   = $clog2(MAX_KNOTS);
    localparam int CNT_W    = $clog2(MAX_KNOTS + 1);
    localparam int POS_W    = FRACTION_BITS + 1;           // Q1.FB position
    localparam int ONE_W    = FRACTION_BITS + 1;           // holds t, u = 0..ONE
    localparam int SQ_W     = 2 * ONE_W;                   // t*t and friends
    localparam int TRI_W    = SQ_W + 2;                    // 3*t*u2 with rounding
    localparam int WGT_W    = ONE_W + 1;                   // blend weight
    localparam int ACC_W    = COORD_W + FRACTION_BITS;     // bits that reach the output
    localparam int SCALED_W = POS_W + CNT_W;               // pos * (count-1)
    localparam int SEGIDX_W = SCALED_W - FRACTION_BITS;

    localparam int NUM_TERMS = 4;
    localparam int TERM_W    = $clog2(NUM_TERMS);

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = ((2 * NUM_AXES * COORD_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NUM_AXES * COORD_W + 7) / 8) * 8;
    localparam int POS_LSB    = 2 * NUM_AXES * COORD_W;

    localparam logic [ONE_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam int unsigned HALF = 1 << (FRACTION_BITS - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_EVAL   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SHORT = 2'd2
    } status_t;

    typedef logic [COORD_W-1:0]                coord_t;
    typedef logic [NUM_TERMS-1:0][WGT_W-1:0]   wgt_vec_t;

    // Sequencer to lane: which term to multiply and what to do with the sum
    typedef struct packed {
        logic              acc_clr;
        logic              acc_add;
        logic [TERM_W-1:0] term;
    } lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/pcb_weights.sv]
// ============================================================================
// pcb_weights: cubic Bernstein weight generator
// Two registered multiply stages turn the segment fraction t into w0..w3.
// ============================================================================
`default_nettype none

module pcb_weights
    import pcb_pkg::*;
(
    input  logic             clk,
    input  logic [ONE_W-1:0] t,        // must hold steady for two cycles
    output wgt_vec_t         w
);

    logic [ONE_W-1:0] u;
    logic [SQ_W-1:0]  tt_sum;
    logic [SQ_W-1:0]  uu_sum;
    logic [ONE_W-1:0] t2_reg;
    logic [ONE_W-1:0] u2_reg;
    logic [ONE_W-1:0] t2_next;
    logic [ONE_W-1:0] u2_next;

    logic [SQ_W-1:0]  w0_sum;
    logic [SQ_W-1:0]  w3_sum;
    logic [SQ_W-1:0]  tu2_prod;
    logic [SQ_W-1:0]  t2u_prod;
    logic [TRI_W-1:0] w1_sum;
    logic [TRI_W-1:0] w2_sum;
    wgt_vec_t         w_reg;
    wgt_vec_t         w_next;

    assign u = ONE - t;

    // Stage 1: rounded squares
    assign tt_sum  = SQ_W'(t) * SQ_W'(t) + SQ_W'(HALF);
    assign uu_sum  = SQ_W'(u) * SQ_W'(u) + SQ_W'(HALF);
    assign t2_next = tt_sum[FRACTION_BITS + ONE_W - 1:FRACTION_BITS];
    assign u2_next = uu_sum[FRACTION_BITS + ONE_W - 1:FRACTION_BITS];

    // Stage 2: cubes and the two mixed terms, times three by shift and add
    assign w0_sum   = SQ_W'(u2_reg) * SQ_W'(u) + SQ_W'(HALF);
    assign w3_sum   = SQ_W'(t2_reg) * SQ_W'(t) + SQ_W'(HALF);
    assign tu2_prod = SQ_W'(t) * SQ_W'(u2_reg);
    assign t2u_prod = SQ_W'(t2_reg) * SQ_W'(u);
    assign w1_sum   = (TRI_W'(tu2_prod) << 1) + TRI_W'(tu2_prod) + TRI_W'(HALF);
    assign w2_sum   = (TRI_W'(t2u_prod) << 1) + TRI_W'(t2u_prod) + TRI_W'(HALF);

    always_comb
    begin
        w_next[0] = w0_sum[FRACTION_BITS + WGT_W - 1:FRACTION_BITS];
        w_next[1] = w1_sum[FRACTION_BITS + WGT_W - 1:FRACTION_BITS];
        w_next[2] = w2_sum[FRACTION_BITS + WGT_W - 1:FRACTION_BITS];
        w_next[3] = w3_sum[FRACTION_BITS + WGT_W - 1:FRACTION_BITS];
    end

    always_ff @(posedge clk)
    begin
        t2_reg <= t2_next;
        u2_reg <= u2_next;
        w_reg  <= w_next;
    end

    assign w = w_reg;

endmodule

`default_nettype wire

[rtl/pcb_lane.sv]
// ============================================================================
// pcb_lane: one coordinate lane
// Holds the knot and handle store of one axis and blends the four control
// values of a segment with one shared multiplier, one term per cycle.
// ============================================================================
`default_nettype none

module pcb_lane
    import pcb_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  coord_t            knot_wdata,
    input  coord_t            handle_wdata,
    input  logic [ADDR_W-1:0] rd_addr,
    input  wgt_vec_t          w,
    input  lane_ctrl_t        ctrl,
    output coord_t            result
);

    logic [COORD_W-1:0] knot_mem   [MAX_KNOTS];
    logic [COORD_W-1:0] handle_mem [MAX_KNOTS];

    logic [ADDR_W-1:0]                 rd_addr_nxt;
    logic [NUM_TERMS-1:0][COORD_W-1:0] pt_reg;

    logic signed [COORD_W-1:0]         mul_a;
    logic signed [WGT_W:0]             mul_b;
    logic signed [COORD_W+WGT_W:0]     prod_full;
    logic [ACC_W-1:0]                  prod_reg;
    logic [ACC_W-1:0]                  prod_next;
    logic [ACC_W-1:0]                  acc_reg;
    logic [ACC_W-1:0]                  acc_next;
    logic [ACC_W-1:0]                  rounded;

    assign rd_addr_nxt = rd_addr + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_mem[wr_addr]   <= knot_wdata;
            handle_mem[wr_addr] <= handle_wdata;
        end
    end

    // Segment control values in blend order: P0 P1 P2 P3
    always_ff @(posedge clk)
    begin
        pt_reg[0] <= knot_mem[rd_addr];
        pt_reg[1] <= handle_mem[rd_addr];
        pt_reg[2] <= handle_mem[rd_addr_nxt];
        pt_reg[3] <= knot_mem[rd_addr_nxt];
    end

    assign mul_a     = $signed(pt_reg[ctrl.term]);
    assign mul_b     = $signed({1'b0, w[ctrl.term]});
    assign prod_full = mul_a * mul_b;
    assign prod_next = prod_full[ACC_W-1:0];

    // Only the low ACC_W bits reach the output, so wrap the sum there
    always_comb
    begin
        priority if (ctrl.acc_clr)
            acc_next = '0;
        else if (ctrl.acc_add)
            acc_next = acc_reg + prod_reg;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rounded = acc_reg + ACC_W'(HALF);
    assign result  = rounded[ACC_W-1:FRACTION_BITS];

endmodule

`default_nettype wire

[rtl/piecewise_cubic_bezier_eval_unit.sv]
// ============================================================================
// piecewise_cubic_bezier_eval_unit: piecewise cubic Bezier store and evaluator
// Knot store with clear and append, and a three-lane Bernstein evaluator.
// ============================================================================
// The block keeps a curve of up to MAX_KNOTS knots, each a 3D point and a 3D
// control handle in signed Q16.16. A clear transaction empties the curve, an
// append transaction adds one knot (dropped when the store is full) and an
// evaluate transaction samples the curve at an unsigned Q1.16 position,
// returning one result transaction with the blended point and a status code.
// Clear and append finish in the cycle they are accepted, so one can follow
// every cycle. An evaluate occupies the block from acceptance until the next
// transaction can be taken: it finds the segment, runs the weight multiplier
// chain (overlapped with the store read), steps the single multiplier each
// coordinate lane shares over the four blend terms, and loads the output
// register; an evaluate with a range or short status goes straight to that
// last step. The output register lets new transactions enter while an earlier
// result still waits. Store contents are not cleared at reset; only knots
// appended since the last clear or reset are ever read.
// ============================================================================
`default_nettype none

module piecewise_cubic_bezier_eval_unit
    import pcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // knot_x, knot_y, knot_z, handle_x, handle_y, handle_z, position, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]   m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_LOAD,
        ST_WGT,
        ST_MAC,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [TERM_W-1:0]     term_reg;
    logic [TERM_W-1:0]     term_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic [STATUS_W-1:0]   m_tuser_reg;
    logic [STATUS_W-1:0]   m_tuser_next;

    logic [POS_W-1:0]      pos_reg;
    logic [ADDR_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]     idx_next;
    logic [ONE_W-1:0]      t_reg;
    logic [ONE_W-1:0]      t_next;

    kind_t                 kind;
    logic [POS_W-1:0]      in_pos;
    logic                  in_fire;
    status_t               eval_status;
    logic                  wr_en;
    lane_ctrl_t            ctrl;

    logic [CNT_W-1:0]      seg_span;
    logic [CNT_W-1:0]      last_seg;
    logic [SCALED_W-1:0]   scaled;
    logic [SEGIDX_W-1:0]   seg_idx;
    logic                  clamp;

    wgt_vec_t              w;
    coord_t                lane_result [NUM_AXES];

    assign kind     = kind_t'(s_tuser);
    assign in_pos   = s_tdata[POS_LSB +: POS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Range check comes before the knot count check
    always_comb
    begin
        priority if (in_pos > ONE)
            eval_status = STATUS_RANGE;
        else if (count_reg < CNT_W'(2))
            eval_status = STATUS_SHORT;
        else
            eval_status = STATUS_OK;
    end

    // Segment select: idx = floor(pos * (count-1)), clamp at the curve end
    assign seg_span = count_reg - CNT_W'(1);
    assign last_seg = count_reg - CNT_W'(2);
    assign scaled   = SCALED_W'(pos_reg) * SCALED_W'(seg_span);
    assign seg_idx  = scaled[SCALED_W-1:FRACTION_BITS];
    assign clamp    = (seg_idx >= SEGIDX_W'(seg_span));
    assign idx_next = clamp ? last_seg[ADDR_W-1:0] : seg_idx[ADDR_W-1:0];
    assign t_next   = clamp ? ONE : {1'b0, scaled[FRACTION_BITS-1:0]};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        term_next     = term_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        ctrl.acc_clr  = 1'b0;
        ctrl.acc_add  = 1'b0;
        ctrl.term     = term_reg;

        // Drop the result once the downstream side takes it
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_KNOTS))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_EVAL:
                        begin
                            status_next = eval_status;
                            state_next  = (eval_status == STATUS_OK) ? ST_SEG : ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEG:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                term_next  = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // Product of the previous term lands while this one multiplies
                ctrl.acc_clr = (term_reg == '0);
                ctrl.acc_add = (term_reg != '0);
                term_next    = term_reg + TERM_W'(1);
                if (term_reg == TERM_W'(NUM_TERMS - 1))
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.acc_add = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Merge the lanes into one result; hold while the output is full
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    if (status_reg == STATUS_OK)
                        m_tdata_next = {lane_result[2], lane_result[1], lane_result[0]};
                    else
                        m_tdata_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            term_reg     <= '0;
            status_reg   <= STATUS_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            term_reg     <= term_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    // Evaluate operands; held steady for the whole evaluation
    always_ff @(posedge clk)
    begin
        if (in_fire && kind == KIND_EVAL)
            pos_reg <= in_pos;
        if (state_reg == ST_SEG)
        begin
            idx_reg <= idx_next;
            t_reg   <= t_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pcb_weights u_weights (
        .clk (clk),
        .t   (t_reg),
        .w   (w)
    );

    for (genvar ax = 0; ax < NUM_AXES; ax++)
    begin : g_lane
        pcb_lane u_lane (
            .clk          (clk),
            .wr_en        (wr_en),
            .wr_addr      (count_reg[ADDR_W-1:0]),
            .knot_wdata   (s_tdata[ax * COORD_W +: COORD_W]),
            .handle_wdata (s_tdata[(NUM_AXES + ax) * COORD_W +: COORD_W]),
            .rd_addr      (idx_reg),
            .w            (w),
            .ctrl         (ctrl),
            .result       (lane_result[ax])
        );
    end

    // An append to a full store leaves the knot count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == KIND_APPEND && count_reg == CNT_W'(MAX_KNOTS))
        |=> $stable(count_reg))
        else $error("append to a full store changed the knot count");

    // A result only appears out of the final evaluation step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

    // Error results carry zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg != STATUS_OK) |-> (m_tdata_reg == '0))
        else $error("error result with nonzero coordinates");

    // The selected segment never reads past the last stored knot
    a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg))
        else $error("segment index beyond the stored knots");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ============================================================================
// testbench: self-checking bench for piecewise_cubic_bezier_eval_unit
// Drives clear, append, evaluate and unused transactions into the stream
// input, predicts every curve sample from its own copy of the knot store,
// and checks each result transaction field by field under random idling on
// both sides, including one long output hold-off that backs up the input.
// ============================================================================
`default_nettype none

module testbench;
    import pcb_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int MAX_GAP        = 12;
    localparam int RANDOM_ITEMS   = 650;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int POS_ONE        = 1 << FRACTION_BITS;

    // Kind code the block leaves undefined; it must be ignored
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        coord_t  coord[NUM_AXES];
        status_t status;
    } curve_point_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the knot store and queues predicted curve samples
    // ------------------------------------------------------------------------
    class curve_scoreboard;
        int unsigned               knot_count = 0;
        logic signed [COORD_W-1:0] knot_pt   [MAX_KNOTS][NUM_AXES];
        logic signed [COORD_W-1:0] handle_pt [MAX_KNOTS][NUM_AXES];
        curve_point_t              pending_points[$];
        int errors          = 0;
        int results_checked = 0;
        int samples_ok      = 0;
        int samples_range   = 0;
        int samples_short   = 0;
        int dropped_appends = 0;

        // Bernstein blend of one axis, rounded to nearest, wrapped to 32 bits
        function coord_t blend_axis(logic signed [COORD_W-1:0] p0,
                                    logic signed [COORD_W-1:0] p1,
                                    logic signed [COORD_W-1:0] p2,
                                    logic signed [COORD_W-1:0] p3,
                                    longint w[NUM_TERMS]);
            longint acc;
            acc = longint'(p0) * w[0] + longint'(p1) * w[1]
                + longint'(p2) * w[2] + longint'(p3) * w[3];
            acc = (acc + longint'(HALF)) >>> FRACTION_BITS;
            return coord_t'(acc);
        endfunction

        function curve_point_t predict_point(logic [POS_W-1:0] pos);
            curve_point_t      pt;
            longint unsigned   one_q;
            longint unsigned   half_q;
            longint unsigned   scaled;
            longint unsigned   t;
            longint unsigned   u;
            longint unsigned   t2;
            longint unsigned   u2;
            longint            w[NUM_TERMS];
            int unsigned       seg;
            one_q  = 64'd1 << FRACTION_BITS;
            half_q = one_q >> 1;
            for (int a = 0; a < NUM_AXES; a++)
                pt.coord[a] = '0;
            pt.status = STATUS_OK;
            // Range check wins over the knot count check
            if (64'(pos) > one_q)
            begin
                pt.status = STATUS_RANGE;
                samples_range++;
                return pt;
            end
            if (knot_count < 2)
            begin
                pt.status = STATUS_SHORT;
                samples_short++;
                return pt;
            end
            scaled = 64'(pos) * 64'(knot_count - 1);
            seg    = int'(scaled >> FRACTION_BITS);
            t      = scaled & (one_q - 1);
            // Curve end: stay on the last segment with t at one
            if (seg >= knot_count - 1)
            begin
                seg = knot_count - 2;
                t   = one_q;
            end
            u    = one_q - t;
            t2   = (t * t + half_q) >> FRACTION_BITS;
            u2   = (u * u + half_q) >> FRACTION_BITS;
            w[0] = longint'((u2 * u + half_q) >> FRACTION_BITS);
            w[1] = longint'((3 * t * u2 + half_q) >> FRACTION_BITS);
            w[2] = longint'((3 * t2 * u + half_q) >> FRACTION_BITS);
            w[3] = longint'((t2 * t + half_q) >> FRACTION_BITS);
            for (int a = 0; a < NUM_AXES; a++)
                pt.coord[a] = blend_axis(knot_pt[seg][a], handle_pt[seg][a],
                                         handle_pt[seg + 1][a], knot_pt[seg + 1][a], w);
            samples_ok++;
            return pt;
        endfunction

        // Record an accepted input transaction
        function void note_item(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
            case (kind)
                KIND_CLEAR:
                    knot_count = 0;
                KIND_APPEND:
                    if (knot_count < MAX_KNOTS)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            knot_pt[knot_count][a]   = data[a * COORD_W +: COORD_W];
                            handle_pt[knot_count][a] = data[(NUM_AXES + a) * COORD_W +: COORD_W];
                        end
                        knot_count++;
                    end
                    else
                        dropped_appends++;
                KIND_EVAL:
                    pending_points.insert(pending_points.size(),
                                          predict_point(data[POS_LSB +: POS_W]));
                default:
                    ;
            endcase
        endfunction

        // Compare an accepted result transaction with the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
            curve_point_t exp_pt;
            string        axis_name[NUM_AXES];
            coord_t       got;
            axis_name = '{"out_x", "out_y", "out_z"};
            results_checked++;
            if (pending_points.size() == 0)
            begin
                $error("result with no sample pending: data %h status %0d", data, st);
                errors++;
                return;
            end
            exp_pt = pending_points.pop_front();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                got = data[a * COORD_W +: COORD_W];
                if (got !== exp_pt.coord[a])
                begin
                    $error("%s mismatch: expected %h, actual %h",
                           axis_name[a], exp_pt.coord[a], got);
                    errors++;
                end
            end
            if (st !== exp_pt.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", exp_pt.status, st);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // knot_x, knot_y, knot_z, handle_x, handle_y, handle_z, position, zero pad
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // kind
    logic [KIND_W-1:0]     s_tuser  = KIND_CLEAR;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_x, out_y, out_z
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [STATUS_W-1:0]   m_tuser;

    piecewise_cubic_bezier_eval_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    curve_scoreboard board = new();

    bit sender_burst   = 1'b0;    // no gaps between input transactions
    bit receiver_burst = 1'b0;    // no stalls between result transactions
    int items_sent     = 0;       // transactions other than the unused kind
    int ignored_sent   = 0;

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic coord_t rand_coord(bit full_range);
        if (full_range)
            return coord_t'($urandom);
        // Keep most curves within +/-16 units so results stay meaningful
        return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    function automatic logic [IN_DATA_W-1:0] make_item(coord_t kx, coord_t ky, coord_t kz,
                                                       coord_t hx, coord_t hy, coord_t hz,
                                                       logic [POS_W-1:0] pos);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[0 * COORD_W +: COORD_W] = kx;
        data[1 * COORD_W +: COORD_W] = ky;
        data[2 * COORD_W +: COORD_W] = kz;
        data[3 * COORD_W +: COORD_W] = hx;
        data[4 * COORD_W +: COORD_W] = hy;
        data[5 * COORD_W +: COORD_W] = hz;
        data[POS_LSB +: POS_W]       = pos;
        return data;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    // Called at a rising edge; valid stays high straight through when no gap.
    task automatic send_item(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_item(kind, data);
        if (kind == KIND_UNUSED)
            ignored_sent++;
        else
            items_sent++;
    endtask

    function automatic logic [IN_DATA_W-1:0] noise_data();
        return make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         POS_W'($urandom_range(0, POS_MAX)));
    endfunction

    task automatic clear_curve();
        send_item(KIND_CLEAR, noise_data());
    endtask

    task automatic send_unused();
        send_item(KIND_UNUSED, noise_data());
    endtask

    task automatic append_knot(coord_t kx, coord_t ky, coord_t kz,
                               coord_t hx, coord_t hy, coord_t hz);
        send_item(KIND_APPEND, make_item(kx, ky, kz, hx, hy, hz,
                                         POS_W'($urandom_range(0, POS_MAX))));
    endtask

    task automatic append_random_knot(bit full_range);
        append_knot(rand_coord(full_range), rand_coord(full_range), rand_coord(full_range),
                    rand_coord(full_range), rand_coord(full_range), rand_coord(full_range));
    endtask

    // Knot fields are ignored on evaluate; fill them with noise
    task automatic sample_curve(logic [POS_W-1:0] pos);
        send_item(KIND_EVAL, make_item($urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, pos));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, burst stretches and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int results_taken;
        stall_left    = 0;
        results_taken = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                board.check_result(m_tdata, m_tuser);
                results_taken++;
                if ($urandom_range(0, 15) == 0)
                    receiver_burst = ~receiver_burst;
                stall_left = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
                // Hold off long enough for the block to fill and stall its input
                if (results_taken == HOLD_AT_RESULT)
                    stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no transaction on either side
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int random_start;
        int curve_no;
        int n_knots;
        int n_samples;
        int pick;
        int seg_k;
        int pos_val;
        bit full_range;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty curve, range precedence, single knot, coordinate
        // extremes with wraparound, curve end clamp, segment boundary, unused
        // kind and clear.
        sample_curve(17'(0));
        sample_curve(17'(POS_MAX));
        send_unused();
        append_knot(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        sample_curve(17'(0));
        append_knot(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        sample_curve(17'(0));
        sample_curve(17'(POS_ONE));
        sample_curve(17'(POS_ONE / 2));
        sample_curve(17'(POS_ONE - 1));
        sample_curve(17'(POS_ONE + 1));
        append_knot(32'h0002_8000, 32'hFFFE_0000, 32'h0000_4000,
                    32'h0001_0000, 32'h0000_0000, 32'hFFFF_8000);
        sample_curve(17'(POS_ONE));
        sample_curve(17'(POS_ONE / 2));
        sample_curve(17'(POS_ONE / 2 - 1));
        send_unused();
        clear_curve();
        sample_curve(17'(POS_ONE / 2));
        append_random_knot(1'b0);
        append_random_knot(1'b0);
        sample_curve(17'($urandom_range(0, POS_ONE)));

        // Random: mostly well-formed curves (clear, appends, samples) with
        // random content; some skipped clears, tiny curves, overfilled stores
        // and stray transactions mixed in.
        random_start = items_sent;
        curve_no     = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            full_range   = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) != 0)
                clear_curve();
            pick = $urandom_range(0, 19);
            if (curve_no == 2)
                n_knots = MAX_KNOTS + 2;
            else if (pick == 0)
                n_knots = $urandom_range(MAX_KNOTS - 4, MAX_KNOTS + 6);
            else if (pick == 1)
                n_knots = $urandom_range(0, 1);
            else
                n_knots = $urandom_range(2, 8);
            for (int k = 0; k < n_knots; k++)
            begin
                append_random_knot(full_range);
                if ($urandom_range(0, 15) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_unused();
                    else
                        sample_curve(17'($urandom_range(0, POS_MAX)));
                end
            end
            n_samples = $urandom_range(3, 12);
            for (int s = 0; s < n_samples; s++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0: pos_val = 0;
                    1: pos_val = POS_ONE;
                    2: pos_val = $urandom_range(POS_ONE + 1, POS_MAX);
                    3:
                    begin
                        // Land on or beside a segment boundary
                        if (board.knot_count >= 2)
                        begin
                            seg_k   = $urandom_range(0, board.knot_count - 1);
                            pos_val = (seg_k * POS_ONE) / int'(board.knot_count - 1)
                                    + int'($urandom_range(0, 2)) - 1;
                            if (pos_val < 0)
                                pos_val = 0;
                            if (pos_val > POS_ONE)
                                pos_val = POS_ONE;
                        end
                        else
                            pos_val = $urandom_range(0, POS_ONE);
                    end
                    default: pos_val = $urandom_range(0, POS_ONE);
                endcase
                sample_curve(17'(pos_val));
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_unused();
                    else
                        append_random_knot(full_range);
                end
            end
            curve_no++;
        end
        s_tvalid <= 1'b0;

        // Drain outstanding samples, then watch for stray results
        while (board.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transactions plus %0d of the unused kind over %0d random curves.",
                 items_sent, ignored_sent, curve_no);
        $display("Samples checked: %0d on the curve, %0d past the end, %0d on short curves;",
                 board.samples_ok, board.samples_range, board.samples_short);
        $display("%0d appends dropped on a full store.", board.dropped_appends);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[piecewise_cubic_bezier_eval_unit.f]
rtl/pcb_pkg.sv
rtl/pcb_weights.sv
rtl/pcb_lane.sv
rtl/piecewise_cubic_bezier_eval_unit.sv
tb/sv/testbench.sv
